@@ src/eqd_pkg.sv @@
// ----------------------------------------------------------------------------
// eqd_pkg
// shared types and fixed-point constants for the equirectangular distance block
// ----------------------------------------------------------------------------
package eqd_pkg;

    // pi in Q30, used to turn the half-degree latitude sum into radians
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [30:0] DIV_D    = 31'd1800000000;
    localparam logic [30:0] HALF_D   = 31'd900000000;
    localparam logic [31:0] RECIP_D  = 32'(64'h4000_0000_0000_0000 / 64'd1800000000);
    localparam logic [31:0] LAT_WRAP = 32'd1800000000;
    localparam logic [31:0] LAT_TURN = 32'd3600000000;
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;

    localparam int unsigned HORNER_STEPS = 7;
    localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
        '{8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

    // radius times radians per 1e-7 degree, Q32
    localparam logic [37:0] G_MM =
        38'((64'd6371 * 64'd13493037705 + 64'd900) / 64'd1800);
    localparam logic [37:0] G_FT =
        38'((64'(G_MM) * 64'd328084 + 64'd50000) / 64'd100000);

    localparam logic [37:0] DIST_MAX = '1;

    localparam int unsigned ROOT_W = 48;
    localparam int unsigned RAD_W  = 2 * ROOT_W;

    typedef struct packed {
        logic [31:0] dlat;
        logic [32:0] dlon;
    } side_t;

endpackage

@@ src/equirectangular_distance_top.sv @@
// ----------------------------------------------------------------------------
// equirectangular_distance_top
// flat-earth distance between two lat/lon points, scaled to mm or milli-feet
// ----------------------------------------------------------------------------
//  channel  | signals                            | dir | transfer when
//  ---------+------------------------------------+-----+----------------------
//  in       | in_valid, in_stall, lat/lon a & b  | in  | in_valid & !in_stall
//  out      | out_valid, out_stall, distance     | out | out_valid & !out_stall
//  cfg      | cfg_write_en, cfg_write_data       | in  | cfg_write_en
//
//  one pair per cycle unless out_stall freezes the pipeline; stages in order:
//  front, cosine, squares, square root, scaling
//  reset clears all valid bits and selects millimetres
//  out_stall with a waiting result freezes the whole pipeline in place
// ----------------------------------------------------------------------------
module equirectangular_distance_top
    import eqd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [30:0] lat_a,
    input  logic signed [31:0] lon_a,
    input  logic signed [30:0] lat_b,
    input  logic signed [31:0] lon_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [37:0]        distance
);

    logic en;
    logic unit_feet_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_feet_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unit_feet_reg <= cfg_write_data;
        end
    end

    // front: sums, differences, absolute values
    logic [1:0]  pre_v_reg;
    logic [31:0] s_reg;
    logic [31:0] dlat_d_reg;
    logic [32:0] dlon_d_reg;
    logic [30:0] a_reg;
    side_t       side_reg;
    logic [31:0] s_abs;
    logic [31:0] a_next;
    side_t       side_next;

    assign s_abs  = s_reg[31] ? (~s_reg + 32'd1) : s_reg;
    // fold past ninety degrees, only the cosine magnitude matters
    assign a_next = (s_abs > LAT_WRAP) ? LAT_TURN - s_abs : s_abs;
    assign side_next.dlat = dlat_d_reg[31] ? (~dlat_d_reg + 32'd1) : dlat_d_reg;
    assign side_next.dlon = dlon_d_reg[32] ? (~dlon_d_reg + 33'd1) : dlon_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= '0;
        end
        else if (en)
        begin
            pre_v_reg <= {pre_v_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= {lat_a[30], lat_a} + {lat_b[30], lat_b};
            dlat_d_reg <= {lat_b[30], lat_b} - {lat_a[30], lat_a};
            dlon_d_reg <= {lon_b[31], lon_b} - {lon_a[31], lon_a};
            a_reg      <= a_next[30:0];
            side_reg   <= side_next;
        end
    end

    logic        cos_valid;
    logic [31:0] cosine;
    side_t       cos_side;

    eqd_cos u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_v_reg[1]),
        .angle     (a_reg),
        .side_in   (side_reg),
        .out_valid (cos_valid),
        .cosine    (cosine),
        .side_out  (cos_side)
    );

    // squared components
    logic [2:0]       mid_v_reg;
    logic [63:0]      bp_reg;
    logic [63:0]      asq_reg;
    logic [63:0]      asq4_reg;
    logic [47:0]      bhh_reg;
    logic [47:0]      bhl_reg;
    logic [47:0]      bll_reg;
    logic [RAD_W-1:0] sum_reg;
    logic [47:0]      b_val;

    assign b_val = bp_reg[63:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_v_reg <= '0;
        end
        else if (en)
        begin
            mid_v_reg <= {mid_v_reg[1:0], cos_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bp_reg   <= 64'(cos_side.dlon) * 64'(cosine);
            asq_reg  <= 64'(cos_side.dlat) * 64'(cos_side.dlat);
            bhh_reg  <= 48'(b_val[47:24]) * 48'(b_val[47:24]);
            bhl_reg  <= 48'(b_val[47:24]) * 48'(b_val[23:0]);
            bll_reg  <= 48'(b_val[23:0]) * 48'(b_val[23:0]);
            asq4_reg <= asq_reg;
            // latitude term carries the Q15 scale twice
            sum_reg  <= (RAD_W'(asq4_reg) << 30) + (RAD_W'(bhh_reg) << 48)
                      + (RAD_W'(bhl_reg) << 25) + RAD_W'(bll_reg);
        end
    end

    logic              root_valid;
    logic [ROOT_W-1:0] root;

    eqd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_v_reg[2]),
        .radicand  (sum_reg),
        .out_valid (root_valid),
        .root      (root)
    );

    // scale to output unit with rounding
    logic [3:0]  post_v_reg;
    logic [47:0] phh_reg;
    logic [47:0] phl_reg;
    logic [47:0] plh_reg;
    logic [47:0] pll_reg;
    logic [47:0] hh_reg;
    logic [47:0] ll_reg;
    logic [48:0] pmid_reg;
    logic [85:0] acc_reg;
    logic [37:0] distance_reg;
    logic [37:0] g_sel;

    assign g_sel = unit_feet_reg ? G_FT : G_MM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_v_reg <= '0;
        end
        else if (en)
        begin
            post_v_reg <= {post_v_reg[2:0], root_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phh_reg  <= 48'(root[47:24]) * 48'(g_sel[37:24]);
            phl_reg  <= 48'(root[47:24]) * 48'(g_sel[23:0]);
            plh_reg  <= 48'(root[23:0]) * 48'(g_sel[37:24]);
            pll_reg  <= 48'(root[23:0]) * 48'(g_sel[23:0]);
            pmid_reg <= 49'(phl_reg) + 49'(plh_reg);
            hh_reg   <= phh_reg;
            ll_reg   <= pll_reg;
            acc_reg  <= (86'(hh_reg) << 48) + (86'(pmid_reg) << 24) + 86'(ll_reg)
                      + (86'd1 << 46);
            distance_reg <= acc_reg[85] ? DIST_MAX : acc_reg[84:47];
        end
    end

    assign en        = !(post_v_reg[3] && out_stall);
    assign in_stall  = !en;
    assign out_valid = post_v_reg[3];
    assign distance  = distance_reg;

endmodule

@@ src/eqd_cos.sv @@
// ----------------------------------------------------------------------------
// eqd_cos
// pipelined cosine of the mid-latitude, Horner series with unsigned Q31 result
// ----------------------------------------------------------------------------
module eqd_cos
    import eqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [30:0] angle,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [31:0] cosine,
    output side_t       side_out
);

    // front: angle to radians and square
    logic [6:0]  fv_reg;
    side_t       fs_reg [7];
    logic [62:0] n_reg;
    logic [64:0] qp_reg;
    logic [33:0] n2_reg;
    logic [33:0] n3_reg;
    logic [31:0] qe3_reg;
    logic [31:0] qe4_reg;
    logic [33:0] dp_reg;
    logic [33:0] r_reg;
    logic [31:0] th_reg;
    logic [63:0] sq_reg;
    logic [32:0] x0_reg;
    logic [31:0] qe_next;
    logic [31:0] th_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[5:0], in_valid};
        end
    end

    assign qe_next = qp_reg[63:32];
    assign th_next = qe4_reg
                   + 32'(r_reg >= 34'(DIV_D))
                   + 32'(r_reg >= 34'(2 * 64'(DIV_D)))
                   + 32'(r_reg >= 34'(3 * 64'(DIV_D)));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= 63'(angle) * 63'(PI_Q30) + 63'(HALF_D);
            // reciprocal estimate, low by at most three
            qp_reg  <= 65'(n_reg[62:30]) * 65'(RECIP_D);
            n2_reg  <= n_reg[33:0];
            qe3_reg <= qe_next;
            dp_reg  <= 34'(34'(qe_next) * 34'(DIV_D));
            n3_reg  <= n2_reg;
            r_reg   <= n3_reg - dp_reg;
            qe4_reg <= qe3_reg;
            th_reg  <= th_next;
            sq_reg  <= 64'(th_reg) * 64'(th_reg);
            x0_reg  <= 33'((65'(sq_reg) + 65'(64'h4000_0000)) >> 31);
            fs_reg[0] <= side_in;
            for (int i = 1; i < 7; i++)
            begin
                fs_reg[i] <= fs_reg[i-1];
            end
        end
    end

    // Horner steps, four stages each
    logic [3:0]  hv_reg  [HORNER_STEPS];
    side_t       hs_reg  [HORNER_STEPS][4];
    logic [63:0] hp_reg  [HORNER_STEPS];
    logic [32:0] ht_reg  [HORNER_STEPS];
    logic [62:0] hq_reg  [HORNER_STEPS];
    logic [29:0] he_reg  [HORNER_STEPS];
    logic [8:0]  hr_reg  [HORNER_STEPS];
    logic [31:0] hc_reg  [HORNER_STEPS];
    logic [32:0] hx1_reg [HORNER_STEPS];
    logic [32:0] hx2_reg [HORNER_STEPS];
    logic [32:0] hx3_reg [HORNER_STEPS];
    logic [32:0] hx4_reg [HORNER_STEPS];

    for (genvar g = 0; g < HORNER_STEPS; g++)
    begin : g_step
        localparam logic [8:0]  DIV   = 9'(HORNER_DIV[g]);
        localparam logic [29:0] RECIP = 30'(34'h2_0000_0000 / 34'(HORNER_DIV[g]));

        logic [32:0] x_in;
        logic [31:0] c_in;
        logic        v_in;
        side_t       s_in;
        logic [29:0] he_next;
        logic [30:0] q_next;

        if (g == 0)
        begin : g_first
            assign x_in = x0_reg;
            assign c_in = ONE_Q31;
            assign v_in = fv_reg[6];
            assign s_in = fs_reg[6];
        end
        else
        begin : g_rest
            assign x_in = hx4_reg[g-1];
            assign c_in = hc_reg[g-1];
            assign v_in = hv_reg[g-1][3];
            assign s_in = hs_reg[g-1][3];
        end

        assign he_next = hq_reg[g][62:33];
        // estimate is at most one low
        assign q_next  = 31'(he_reg[g]) + 31'(hr_reg[g] >= DIV);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hv_reg[g] <= '0;
            end
            else if (en)
            begin
                hv_reg[g] <= {hv_reg[g][2:0], v_in};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hp_reg[g]  <= 64'(x_in) * 64'(c_in);
                hx1_reg[g] <= x_in;
                ht_reg[g]  <= hp_reg[g][63:31];
                hq_reg[g]  <= 63'(hp_reg[g][63:31]) * 63'(RECIP);
                hx2_reg[g] <= hx1_reg[g];
                he_reg[g]  <= he_next;
                hr_reg[g]  <= ht_reg[g][8:0] - 9'(he_next[8:0] * DIV);
                hx3_reg[g] <= hx2_reg[g];
                hc_reg[g]  <= (32'(q_next) > ONE_Q31) ? '0 : ONE_Q31 - 32'(q_next);
                hx4_reg[g] <= hx3_reg[g];
                hs_reg[g][0] <= s_in;
                hs_reg[g][1] <= hs_reg[g][0];
                hs_reg[g][2] <= hs_reg[g][1];
                hs_reg[g][3] <= hs_reg[g][2];
            end
        end
    end

    // last term: halve and clamp
    logic [1:0]  tv_reg;
    side_t       ts_reg [2];
    logic [63:0] fp_reg;
    logic [31:0] fc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else if (en)
        begin
            tv_reg <= {tv_reg[0], hv_reg[HORNER_STEPS-1][3]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fp_reg    <= 64'(hx4_reg[HORNER_STEPS-1]) * 64'(hc_reg[HORNER_STEPS-1]);
            fc_reg    <= (fp_reg[63:32] > ONE_Q31) ? '0 : ONE_Q31 - fp_reg[63:32];
            ts_reg[0] <= hs_reg[HORNER_STEPS-1][3];
            ts_reg[1] <= ts_reg[0];
        end
    end

    assign out_valid = tv_reg[1];
    assign cosine    = fc_reg;
    assign side_out  = ts_reg[1];

endmodule

@@ src/eqd_sqrt.sv @@
// ----------------------------------------------------------------------------
// eqd_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module eqd_sqrt
    import eqd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root
);

    logic                valid_reg [ROOT_W];
    logic [RAD_W-1:0]    rad_reg   [ROOT_W];
    logic [ROOT_W+1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]   root_reg  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_bit
        logic                v_prev;
        logic [RAD_W-1:0]    rad_prev;
        logic [ROOT_W+1:0]   rem_prev;
        logic [ROOT_W-1:0]   root_prev;
        logic [ROOT_W+3:0]   rem_sh;
        logic [ROOT_W+3:0]   trial;
        logic                ge;

        if (g == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign v_prev    = valid_reg[g-1];
            assign rad_prev  = rad_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
        end

        assign rem_sh = {rem_prev, rad_prev[RAD_W-1-2*g -: 2]};
        assign trial  = {2'b00, root_prev, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= rad_prev;
                rem_reg[g]  <= (ROOT_W+2)'(ge ? rem_sh - trial : rem_sh);
                root_reg[g] <= {root_prev[ROOT_W-2:0], ge};
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule

@@ tb/sv/equirectangular_distance_top_test.sv @@
// ----------------------------------------------------------------------------
// equirectangular_distance_top_test
// self-checking bench: drives position pairs through the distance pipeline,
// predicts each distance in fixed point and compares every output transfer
// against the oldest pending prediction, in millimetres and milli-feet
// ----------------------------------------------------------------------------
module equirectangular_distance_top_test
    import eqd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DRAIN  = 120;
    localparam int WATCHDOG_LIM = 20000;
    localparam int HOLD_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_en;
    logic               cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               out_valid;
    logic               out_stall;
    logic [37:0]        distance;

    logic [37:0] pending_dist[$];
    logic        feet_sel;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_cnt;
    int          quiet_cycles;
    int          err_cnt;

    equirectangular_distance_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .lat_a          (lat_a),
        .lon_a          (lon_a),
        .lat_b          (lat_b),
        .lon_b          (lon_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance       (distance)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // cosine of the mid-latitude, unsigned Q31
    function automatic logic [127:0] mid_lat_cos(input longint lat_sum);
        logic [127:0] a;
        logic [127:0] th;
        logic [127:0] x;
        logic [127:0] c;
        logic [127:0] p;
        a = (lat_sum < 0) ? 128'(-lat_sum) : 128'(lat_sum);
        if (a > 128'd1800000000)
            a = 128'd3600000000 - a;
        th = (a * 128'd3373259426 + 128'd900000000) / 128'd1800000000;
        x  = (th * th + (128'd1 << 30)) >> 31;
        c  = 128'd1 << 31;
        for (int i = 0; i < HORNER_STEPS; i++)
        begin
            p = ((x * c) >> 31) / 128'(HORNER_DIV[i]);
            c = (p > (128'd1 << 31)) ? 128'd0 : (128'd1 << 31) - p;
        end
        p = ((x * c) >> 31) / 128'd2;
        return (p > (128'd1 << 31)) ? 128'd0 : (128'd1 << 31) - p;
    endfunction

    function automatic logic [37:0] calc_distance(input logic signed [30:0] la,
                                                  input logic signed [31:0] oa,
                                                  input logic signed [30:0] lb,
                                                  input logic signed [31:0] ob,
                                                  input logic feet);
        longint       dlat;
        longint       dlon;
        logic [127:0] c;
        logic [127:0] sa;
        logic [127:0] sb;
        logic [127:0] sum_sq;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] v;
        dlat = longint'(lb) - longint'(la);
        dlon = longint'(ob) - longint'(oa);
        c    = mid_lat_cos(longint'(la) + longint'(lb));
        sa   = ((dlat < 0) ? 128'(-dlat) : 128'(dlat)) << 15;
        sb   = (((dlon < 0) ? 128'(-dlon) : 128'(dlon)) * c) >> 16;
        sum_sq = sa * sa + sb * sb;
        root = '0;
        for (int b = 47; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum_sq)
                root = cand;
        end
        v = (root * 128'(feet ? G_FT : G_MM) + (128'd1 << 46)) >> 47;
        return (v > 128'(DIST_MAX)) ? DIST_MAX : v[37:0];
    endfunction

    // output side: random stall, long hold-off on request, result check
    always @(posedge clk)
    begin
        if (out_valid && !out_stall && rst_n)
        begin
            if (pending_dist.size() == 0)
            begin
                $display("%0t: unexpected distance transfer, actual %0d", $time, distance);
                err_cnt++;
            end
            else
            begin
                logic [37:0] exp_d;
                exp_d = pending_dist.pop_front();
                if (distance !== exp_d)
                begin
                    $display("%0t: distance mismatch, expected %0d actual %0d",
                             $time, exp_d, distance);
                    err_cnt++;
                end
            end
        end
        if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            hold_cnt  <= hold_cnt + 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIM)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_pair(input logic signed [30:0] la, input logic signed [31:0] oa,
                             input logic signed [30:0] lb, input logic signed [31:0] ob);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a    <= la;
        lon_a    <= oa;
        lat_b    <= lb;
        lon_b    <= ob;
        do
            @(posedge clk);
        while (in_stall);
        pending_dist.push_back(calc_distance(la, oa, lb, ob, feet_sel));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_dist.size() == 0);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_unit(input logic feet);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= feet;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        feet_sel = feet;
    endtask

    task automatic send_random();
        logic signed [30:0] la;
        logic signed [31:0] oa;
        logic signed [30:0] lb;
        logic signed [31:0] ob;
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
        begin
            // any bit pattern
            la = $urandom;
            oa = $urandom;
            lb = $urandom;
            ob = $urandom;
        end
        else
        begin
            la = $signed($urandom_range(1800000000)) - 900000000;
            oa = $signed($urandom_range(3600000000)) - 1800000000;
            if (sel == 1)
            begin
                lb = $signed($urandom_range(1800000000)) - 900000000;
                ob = $signed($urandom_range(3600000000)) - 1800000000;
            end
            else
            begin
                // nearby points
                lb = la + $signed($urandom_range(2000000)) - 1000000;
                ob = oa + $signed($urandom_range(2000000)) - 1000000;
            end
        end
        send_pair(la, oa, lb, ob);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(123456789, -98765432, 123456789, -98765432);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 1, 0);
        send_pair(-900000000, -1800000000, 900000000, 1800000000);
        send_pair(900000000, 0, 900000000, 1800000000);
        send_pair(-900000000, 1800000000, -900000000, -1800000000);
        send_pair(0, -1800000000, 0, 1800000000);
        send_pair(600000000, 100000000, 600000000, 200000000);
        // latitudes past 90 degrees fold the cosine
        send_pair(31'sh3FFF_FFFF, 0, 31'sh3FFF_FFFF, 1000000);
        send_pair(-31'sh4000_0000, 0, -31'sh4000_0000, 1000000);
        send_pair(-31'sh4000_0000, 32'sh8000_0000, 31'sh3FFF_FFFF, 32'sh7FFF_FFFF);
        send_pair(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, -31'sh4000_0000, 32'sh8000_0000);
        send_pair(950000000, 5, 850000001, -5);
        send_pair(-31'sh4000_0000, -1, -31'sh4000_0000, -1);
        send_pair(-1, -1, -1, -1);
    endtask

    task automatic test_both_units();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_unit(1'b0);
        test_directed();
        write_unit(1'b1);
        test_directed();
    endtask

    task automatic test_random_phase(input logic feet, input int idle_s,
                                     input int stall_r, input int count);
        write_unit(feet);
        send_idle_pct  = idle_s;
        recv_stall_pct = stall_r;
        repeat (count) send_random();
    endtask

    task automatic test_backpressure();
        write_unit(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cnt = 0;
        hold_req = 1'b1;
        repeat (200) send_random();
        wait (hold_cnt >= HOLD_CYCLES);
        hold_req = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        lat_a          = '0;
        lon_a          = '0;
        lat_b          = '0;
        lon_b          = '0;
        out_stall      = 1'b0;
        feet_sel       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_cnt       = 0;
        quiet_cycles   = 0;
        err_cnt        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_both_units();
        test_random_phase(1'b0, 12, 72, 300);
        test_random_phase(1'b1, 72, 12, 300);
        test_random_phase(1'b1, 0, 0, 150);
        test_random_phase(1'b0, 0, 0, 150);
        test_backpressure();

        wait_idle();
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
